// ===== hdl/lzssd_pkg.sv =====
`timescale 1ns / 1ps

package lzssd_pkg;

    // byte and lane geometry of the result word
    localparam int BYTE_W = 8;
    localparam int LANES = 4;
    localparam int LANE_W = 2;
    localparam int CNT_W = 3;

    // default history ring depth
    localparam int HISTORY_DEPTH_DEF = 256;

    // request from the token sequencer to the history ring
    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [BYTE_W-1:0] wr_data;
        logic [BYTE_W-1:0] rd_dist;
    } hist_req_t;

endpackage

// ===== hdl/lzssd_hist.sv =====
`timescale 1ns / 1ps

module lzssd_hist
    import lzssd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  hist_req_t         req,
    output logic [BYTE_W-1:0] rd_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(HISTORY_DEPTH - 1);

    logic [BYTE_W-1:0] mem [HISTORY_DEPTH];

    logic [AW-1:0]     wp_reg;
    logic              wrapped_reg;
    logic [BYTE_W-1:0] rd_q_reg;
    logic              hit_reg;

    logic [AW-1:0]     dist_ext;
    logic [AW-1:0]     src;
    logic              hit;

    // source slot, distance back from the write pointer modulo the depth
    always_comb begin
        dist_ext = AW'(req.rd_dist);
        if (wp_reg >= dist_ext) begin
            src = wp_reg - dist_ext;
        end else begin
            src = AW'({1'b0, wp_reg} + DEPTH_W - {1'b0, dist_ext});
        end
        // slot holds data only once written since reset
        hit = wrapped_reg || (src < wp_reg);
    end

    // ring storage, one write and one registered read
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[wp_reg] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_q_reg <= mem[src];
            hit_reg <= hit;
        end
    end

    // write pointer and fill tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            wrapped_reg <= 1'b0;
        end else if (req.wr_en) begin
            if (wp_reg == LAST_POS) begin
                wp_reg <= '0;
                wrapped_reg <= 1'b1;
            end else begin
                wp_reg <= wp_reg + AW'(1);
            end
        end
    end

    // never-written slots read as zero
    assign rd_data = hit_reg ? rd_q_reg : '0;

endmodule

// ===== hdl/lzss_escape_code_decoder.sv =====
`timescale 1ns / 1ps
// Literal word: its result passes through the group register, then the output register;
// literals and token bytes sustain one input word per cycle while the output drains.
// Copy token of length L: L bytes, each a read state then a write state, input not ready meanwhile;
// each copied byte is a registered read from the history ring, then a write back into it.
// Reset: synchronous active low; control state cleared, ring slots not written since
// reset read as zero through fill tracking, so no clearing pass is needed.

module lzss_escape_code_decoder
    import lzssd_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_in_byte,
    input  logic              s_end_of_stream,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte0,
    output logic [BYTE_W-1:0] m_out_byte1,
    output logic [BYTE_W-1:0] m_out_byte2,
    output logic [BYTE_W-1:0] m_out_byte3,
    output logic [CNT_W-1:0]  m_byte_count,
    output logic              m_last_group
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ESC,
        ST_DIST,
        ST_READ,
        ST_WRITE
    } state_t;

    state_t            state_reg, state_next;
    logic [BYTE_W-1:0] escape_reg, escape_next;
    logic [BYTE_W-1:0] dist_reg, dist_next;
    logic [BYTE_W-1:0] len_reg, len_next;

    logic [BYTE_W-1:0] acc_byte_reg [LANES];
    logic [BYTE_W-1:0] acc_byte_next [LANES];
    logic [CNT_W-1:0]  acc_cnt_reg, acc_cnt_next;
    logic              acc_last_reg, acc_last_next;
    logic              acc_done_reg, acc_done_next;

    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_byte_reg [LANES];
    logic [BYTE_W-1:0] m_byte_next [LANES];
    logic [CNT_W-1:0]  m_cnt_reg, m_cnt_next;
    logic              m_last_reg, m_last_next;

    hist_req_t         hreq;
    logic [BYTE_W-1:0] hist_rd_data;

    logic out_free;
    logic acc_free;
    logic parsing;
    logic s_fire;

    lzssd_hist #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hreq),
        .rd_data (hist_rd_data)
    );

    // handshake conditions
    assign out_free = !m_valid_reg || m_ready;
    assign acc_free = !acc_done_reg || out_free;
    assign parsing = (state_reg == ST_IDLE) || (state_reg == ST_ESC)
                     || (state_reg == ST_DIST);
    assign s_ready = parsing && acc_free;
    assign s_fire = s_valid && s_ready;

    // token sequencer, group assembly and output register
    always_comb begin
        state_next = state_reg;
        escape_next = cfg_we ? cfg_wdata : escape_reg;
        dist_next = dist_reg;
        len_next = len_reg;
        acc_byte_next = acc_byte_reg;
        acc_cnt_next = acc_cnt_reg;
        acc_last_next = acc_last_reg;
        acc_done_next = acc_done_reg;
        m_valid_next = m_valid_reg;
        m_byte_next = m_byte_reg;
        m_cnt_next = m_cnt_reg;
        m_last_next = m_last_reg;
        hreq.wr_en = 1'b0;
        hreq.rd_en = 1'b0;
        hreq.wr_data = s_in_byte;
        hreq.rd_dist = dist_reg;

        // move a finished group into the output register
        if (acc_done_reg && out_free) begin
            m_valid_next = 1'b1;
            m_byte_next = acc_byte_reg;
            m_cnt_next = acc_cnt_reg;
            m_last_next = acc_last_reg;
            acc_done_next = 1'b0;
            acc_cnt_next = '0;
            for (int i = 0; i < LANES; i++) begin
                acc_byte_next[i] = '0;
            end
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_in_byte == escape_reg) begin
                        state_next = s_end_of_stream ? ST_IDLE : ST_ESC;
                    end else begin
                        hreq.wr_en = 1'b1;
                        acc_byte_next[0] = s_in_byte;
                        acc_cnt_next = CNT_W'(1);
                        acc_last_next = 1'b1;
                        acc_done_next = 1'b1;
                    end
                end
            end
            ST_ESC: begin
                if (s_fire) begin
                    if (s_in_byte == escape_reg) begin
                        // escaped literal
                        hreq.wr_en = 1'b1;
                        acc_byte_next[0] = s_in_byte;
                        acc_cnt_next = CNT_W'(1);
                        acc_last_next = 1'b1;
                        acc_done_next = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        dist_next = (s_in_byte > escape_reg) ? s_in_byte - BYTE_W'(1)
                                                             : s_in_byte;
                        state_next = s_end_of_stream ? ST_IDLE : ST_DIST;
                    end
                end
            end
            ST_DIST: begin
                if (s_fire) begin
                    len_next = s_in_byte;
                    state_next = (s_in_byte == '0) ? ST_IDLE : ST_READ;
                end
            end
            ST_READ: begin
                if (acc_free) begin
                    hreq.rd_en = 1'b1;
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // copied byte goes back into the ring and into the next lane
                hreq.wr_en = 1'b1;
                hreq.wr_data = hist_rd_data;
                acc_byte_next[acc_cnt_reg[LANE_W-1:0]] = hist_rd_data;
                acc_cnt_next = acc_cnt_reg + CNT_W'(1);
                len_next = len_reg - BYTE_W'(1);
                if ((acc_cnt_reg == CNT_W'(LANES - 1)) || (len_reg == BYTE_W'(1))) begin
                    acc_done_next = 1'b1;
                    acc_last_next = (len_reg == BYTE_W'(1));
                end
                state_next = (len_reg == BYTE_W'(1)) ? ST_IDLE : ST_READ;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            escape_reg <= '0;
            dist_reg <= '0;
            len_reg <= '0;
            acc_cnt_reg <= '0;
            acc_last_reg <= 1'b0;
            acc_done_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                acc_byte_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            escape_reg <= escape_next;
            dist_reg <= dist_next;
            len_reg <= len_next;
            acc_byte_reg <= acc_byte_next;
            acc_cnt_reg <= acc_cnt_next;
            acc_last_reg <= acc_last_next;
            acc_done_reg <= acc_done_next;
            m_valid_reg <= m_valid_next;
        end
        m_byte_reg <= m_byte_next;
        m_cnt_reg <= m_cnt_next;
        m_last_reg <= m_last_next;
    end

    // result word ports
    assign m_valid = m_valid_reg;
    assign m_out_byte0 = m_byte_reg[0];
    assign m_out_byte1 = m_byte_reg[1];
    assign m_out_byte2 = m_byte_reg[2];
    assign m_out_byte3 = m_byte_reg[3];
    assign m_byte_count = m_cnt_reg;
    assign m_last_group = m_last_reg;

endmodule
